### rtl/core/bsld_pkg.sv
package bsld_pkg;

    typedef enum logic [1:0] {
        PH_BOOT      = 2'd0,
        PH_OFF       = 2'd1,
        PH_WAIT_LONG = 2'd2,
        PH_WAIT_OFF  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_OFF   = 2'd1,
        EV_SHORT = 2'd2,
        EV_LONG  = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        CFG_ENABLED        = 2'd0,
        CFG_ACTIVE_LOW     = 2'd1,
        CFG_LONG_PUSH_MS   = 2'd2,
        CFG_DEBOUNCE_POLLS = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned HELD_W     = 16;
    localparam int unsigned DEBOUNCE_W = 8;

    localparam logic [HELD_W-1:0]     LONG_PUSH_MS_RST   = 16'd2000;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_POLLS_RST = 8'd5;
    localparam logic [HELD_W-1:0]     HELD_MAX           = 16'hFFFF;

    typedef struct packed {
        logic pin_level;
        logic ms_tick;
    } t_in_item;

    typedef struct packed {
        t_event button_event;
        t_phase detector_state;
    } t_out_item;

endpackage

### rtl/core/bsld_in_if.sv
interface bsld_in_if import bsld_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/bsld_out_if.sv
interface bsld_out_if import bsld_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/button_short_long_press_detector_top.sv
// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    pin_level, ms_tick
// o_rsp     out  valid/ready    button_event, detector_state
// i_cfg_*   in   write enable   index 0..3, 16-bit data
//
// One request per cycle while o_rsp takes results; its result appears in the cycle after
// acceptance, from the single result register after the phase update logic.
// i_req.ready is high while the result register is empty or being taken, so a
// stalled o_rsp holds one result and stops further requests.
// Synchronous active-low reset: phase boot, counters zero, config registers to defaults.
module button_short_long_press_detector_top import bsld_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bsld_in_if.sink               i_req,
    bsld_out_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic                  r_enabled;
    logic                  r_active_low;
    logic [HELD_W-1:0]     r_long_push_ms;
    logic [DEBOUNCE_W-1:0] r_debounce_polls;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [DEBOUNCE_W-1:0] r_debounce_left;
    logic [DEBOUNCE_W-1:0] n_debounce_left;
    logic [HELD_W-1:0]     r_held_ms;
    logic [HELD_W-1:0]     n_held_ms;
    t_event                n_event;

    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  accept;
    logic                  active;
    logic [HELD_W-1:0]     held_inc;

    assign i_req.ready   = !r_out_valid || o_rsp.ready;
    assign accept        = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    assign active   = i_req.payload.pin_level ^ r_active_low;
    assign held_inc = (i_req.payload.ms_tick && (r_held_ms != HELD_MAX)) ?
                      r_held_ms + HELD_W'(1) : r_held_ms;

    always_comb begin
        n_phase         = r_phase;
        n_debounce_left = r_debounce_left;
        n_held_ms       = r_held_ms;
        n_event         = EV_NONE;
        unique case (r_phase)
            PH_BOOT: begin
                if (r_enabled) begin
                    n_phase         = PH_OFF;
                    n_debounce_left = r_debounce_polls;
                    n_event         = EV_OFF;
                end
            end
            PH_OFF: begin
                if (active) begin
                    // zero and one both accept on this poll
                    if (r_debounce_left <= DEBOUNCE_W'(1)) begin
                        n_debounce_left = '0;
                        n_held_ms       = '0;
                        n_phase         = PH_WAIT_LONG;
                    end else begin
                        n_debounce_left = r_debounce_left - DEBOUNCE_W'(1);
                    end
                end else begin
                    n_debounce_left = r_debounce_polls;
                end
            end
            PH_WAIT_LONG: begin
                n_held_ms = held_inc;
                priority if (!active) begin
                    n_event = EV_SHORT;
                    n_phase = PH_WAIT_OFF;
                end else if (held_inc >= r_long_push_ms) begin
                    n_event = EV_LONG;
                    n_phase = PH_WAIT_OFF;
                end
            end
            PH_WAIT_OFF: begin
                if (!active) begin
                    n_phase         = PH_OFF;
                    n_debounce_left = r_debounce_polls;
                    n_event         = EV_OFF;
                end
            end
            default: begin
                n_phase = PH_BOOT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled        <= 1'b0;
            r_active_low     <= 1'b0;
            r_long_push_ms   <= LONG_PUSH_MS_RST;
            r_debounce_polls <= DEBOUNCE_POLLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLED:        r_enabled        <= i_cfg_wdata[0];
                CFG_ACTIVE_LOW:     r_active_low     <= i_cfg_wdata[0];
                CFG_LONG_PUSH_MS:   r_long_push_ms   <= i_cfg_wdata[HELD_W-1:0];
                CFG_DEBOUNCE_POLLS: r_debounce_polls <= i_cfg_wdata[DEBOUNCE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_BOOT;
            r_debounce_left <= '0;
            r_held_ms       <= '0;
        end else begin
            if (accept) begin
                r_phase         <= n_phase;
                r_debounce_left <= n_debounce_left;
                r_held_ms       <= n_held_ms;
            end
            // disable wins over any step in the same cycle
            if (i_cfg_we && (i_cfg_idx == CFG_ENABLED) && !i_cfg_wdata[0]) begin
                r_phase <= PH_BOOT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.button_event   <= n_event;
            r_out.detector_state <= n_phase;
        end
    end

    a_run_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_BOOT) |-> r_enabled)
        else $error("phase left boot while disabled");

    a_wait_long_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT_LONG) |-> (r_debounce_left == '0))
        else $error("debounce count not cleared in wait-long");

    a_press_ends_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out.button_event == EV_LONG) ||
                         (r_out.button_event == EV_SHORT)))
        |-> (r_out.detector_state == PH_WAIT_OFF))
        else $error("press reported outside wait-for-off");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted request produced no result");

    a_off_event_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.button_event == EV_OFF))
        |-> (r_out.detector_state == PH_OFF))
        else $error("off event without off state");

endmodule

### tb/tb_button_short_long_press_detector_top.sv
module tb_button_short_long_press_detector_top;
    import bsld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bsld_in_if  req_if ();
    bsld_out_if rsp_if ();

    button_short_long_press_detector_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // Detector copy: configuration and state
    logic                  cfg_enabled;
    logic                  cfg_active_low;
    logic [HELD_W-1:0]     cfg_long_ms;
    logic [DEBOUNCE_W-1:0] cfg_debounce;
    t_phase                det_phase;
    logic [DEBOUNCE_W-1:0] debounce_left;
    logic [HELD_W-1:0]     held_ms;

    t_out_item expected_rsp[$];
    int        polls_sent;
    int        results_seen;
    int        mismatches;
    int        stall_left;
    int        quiet_cycles;
    bit        idle_on;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_out_item advance_detector(logic pin, logic tick);
        t_out_item r;
        logic      act;
        act = pin ^ cfg_active_low;
        r.button_event = EV_NONE;
        case (det_phase)
            PH_BOOT: begin
                if (cfg_enabled) begin
                    det_phase     = PH_OFF;
                    debounce_left = cfg_debounce;
                    r.button_event = EV_OFF;
                end
            end
            PH_OFF: begin
                if (act) begin
                    if (debounce_left <= 1) begin
                        debounce_left = '0;
                        held_ms       = '0;
                        det_phase     = PH_WAIT_LONG;
                    end else begin
                        debounce_left = debounce_left - 1'b1;
                    end
                end else begin
                    debounce_left = cfg_debounce;
                end
            end
            PH_WAIT_LONG: begin
                if (tick && held_ms != HELD_MAX) begin
                    held_ms = held_ms + 1'b1;
                end
                // release wins over the long check on the same poll
                if (!act) begin
                    r.button_event = EV_SHORT;
                    det_phase      = PH_WAIT_OFF;
                end else if (held_ms >= cfg_long_ms) begin
                    r.button_event = EV_LONG;
                    det_phase      = PH_WAIT_OFF;
                end
            end
            default: begin
                if (!act) begin
                    det_phase      = PH_OFF;
                    debounce_left  = cfg_debounce;
                    r.button_event = EV_OFF;
                end
            end
        endcase
        r.detector_state = det_phase;
        return r;
    endfunction

    function automatic logic pin_for(logic act);
        return act ^ cfg_active_low;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    // Result checker and receiver stalls
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsp.size() == 0) begin
                    flag_mismatch("unexpected result, event", rsp_if.payload.button_event, 0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp_if.payload.button_event !== want.button_event) begin
                        flag_mismatch("button_event", rsp_if.payload.button_event,
                                      want.button_event);
                    end
                    if (rsp_if.payload.detector_state !== want.detector_state) begin
                        flag_mismatch("detector_state", rsp_if.payload.detector_state,
                                      want.detector_state);
                    end
                end
                results_seen++;
            end
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_button_short_long_press_detector_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_poll(logic pin, logic tick);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid             <= 1'b1;
        req_if.payload.pin_level <= pin;
        req_if.payload.ms_tick   <= tick;
        do @(posedge clk); while (!req_if.ready);
        expected_rsp.push_back(advance_detector(pin, tick));
        polls_sent++;
    endtask

    task automatic send_run(logic pin, logic tick, int count);
        repeat (count) send_poll(pin, tick);
    endtask

    // Drop the request and hold until every result is back
    task automatic settle();
        req_if.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_ENABLED: begin
                cfg_enabled = val[0];
                if (!val[0]) begin
                    det_phase = PH_BOOT;
                end
            end
            CFG_ACTIVE_LOW:   cfg_active_low = val[0];
            CFG_LONG_PUSH_MS: cfg_long_ms    = val[HELD_W-1:0];
            default:          cfg_debounce   = val[DEBOUNCE_W-1:0];
        endcase
        cfg_we <= 1'b0;
    endtask

    task automatic setup(logic al, int long_ms, int deb);
        write_reg(CFG_ACTIVE_LOW, CFG_DATA_W'(al));
        write_reg(CFG_LONG_PUSH_MS, CFG_DATA_W'(long_ms));
        write_reg(CFG_DEBOUNCE_POLLS, CFG_DATA_W'(deb));
    endtask

    task automatic test_reset_defaults();
        for (int k = 0; k < 4; k++) begin
            send_poll(k[0], k[1]);
        end
        write_reg(CFG_ENABLED, CFG_DATA_W'(1));
        send_run(1'b0, 1'b1, 2);
        // default debounce of five polls, then a short press
        send_run(1'b1, 1'b1, 6);
        send_run(1'b0, 1'b0, 2);
    endtask

    task automatic test_press_kinds();
        setup(1'b0, 3, 2);
        send_run(1'b0, 1'b0, 1);
        send_run(1'b1, 1'b0, 3);
        send_run(1'b1, 1'b1, 3);
        send_run(1'b1, 1'b1, 2);
        send_run(1'b0, 1'b1, 2);
        send_run(1'b1, 1'b0, 2);
        send_run(1'b1, 1'b1, 1);
        send_run(1'b0, 1'b0, 2);
        // bounce during debounce reloads the count
        send_run(1'b1, 1'b0, 1);
        send_run(1'b0, 1'b0, 1);
        send_run(1'b1, 1'b0, 1);
    endtask

    task automatic test_active_low();
        setup(1'b1, 1, 1);
        send_run(1'b1, 1'b1, 2);
        send_run(1'b0, 1'b1, 3);
        send_run(1'b1, 1'b0, 2);
        send_run(1'b0, 1'b0, 2);
        send_run(1'b1, 1'b1, 2);
    endtask

    task automatic test_zero_settings();
        setup(1'b0, 0, 0);
        send_run(1'b0, 1'b0, 1);
        send_run(1'b1, 1'b0, 3);
        send_run(1'b0, 1'b0, 2);
        send_run(1'b1, 1'b1, 1);
        send_run(1'b0, 1'b1, 2);
    endtask

    task automatic test_delay_change();
        setup(1'b0, 100, 1);
        send_run(1'b0, 1'b0, 1);
        send_run(1'b1, 1'b1, 4);
        write_reg(CFG_LONG_PUSH_MS, CFG_DATA_W'(2));
        send_run(1'b1, 1'b0, 2);
        send_run(1'b0, 1'b0, 1);
    endtask

    task automatic test_disable_midway();
        setup(1'b0, 50, 1);
        send_run(1'b1, 1'b1, 3);
        write_reg(CFG_ENABLED, CFG_DATA_W'(0));
        send_run(1'b1, 1'b1, 2);
        send_run(1'b0, 1'b0, 1);
        write_reg(CFG_ENABLED, CFG_DATA_W'(1));
        send_run(1'b1, 1'b1, 3);
        send_run(1'b0, 1'b0, 2);
    endtask

    task automatic test_debounce_max();
        setup(1'b0, 5, 255);
        send_run(1'b0, 1'b0, 1);
        // the last of these held polls is the one that accepts the press
        send_run(1'b1, 1'b0, 255);
        send_run(1'b0, 1'b0, 2);
    endtask

    task automatic test_max_delay();
        idle_on = 1'b0;
        setup(1'b0, 65535, 1);
        send_run(1'b0, 1'b0, 1);
        send_run(1'b1, 1'b0, 1);
        send_run(1'b1, 1'b1, 12);
        send_run(1'b0, 1'b0, 2);
        idle_on = 1'b1;
    endtask

    task automatic random_presses(int n);
        int stop;
        int hold;
        int lim;
        stop = polls_sent + n;
        while (polls_sent < stop) begin
            if ($urandom_range(0, 9) < 8) begin
                repeat ($urandom_range(1, 4)) send_poll(pin_for(1'b0),
                                                        1'($urandom_range(0, 1)));
                lim = int'(cfg_long_ms) * 2 + 4;
                if (lim > 60) begin
                    lim = 60;
                end
                hold = (cfg_debounce == 0 ? 1 : int'(cfg_debounce)) + $urandom_range(0, lim);
                repeat (hold) send_poll(pin_for(1'b1), $urandom_range(0, 9) < 7);
            end else begin
                repeat ($urandom_range(1, 6)) send_poll(1'($urandom_range(0, 1)),
                                                        1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: setup(1'b0, 0, 1);
                5: setup(1'($urandom_range(0, 1)), 65535, 20);
                default: setup(1'($urandom_range(0, 1)), $urandom_range(1, 12),
                               $urandom_range(1, 8));
            endcase
            idle_on = (ph != 2);
            if (ph == 3) begin
                write_reg(CFG_ENABLED, CFG_DATA_W'(0));
                random_presses(5);
                write_reg(CFG_ENABLED, CFG_DATA_W'(1));
            end
            random_presses(8);
            if (ph == 4) begin
                settle();
                random_presses(8);
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_ENABLED;
        cfg_wdata      = '0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        cfg_enabled    = 1'b0;
        cfg_active_low = 1'b0;
        cfg_long_ms    = LONG_PUSH_MS_RST;
        cfg_debounce   = DEBOUNCE_POLLS_RST;
        det_phase      = PH_BOOT;
        debounce_left  = '0;
        held_ms        = '0;
        polls_sent     = 0;
        results_seen   = 0;
        mismatches     = 0;
        stall_left     = 0;
        quiet_cycles   = 0;
        idle_on        = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_press_kinds();
        test_active_low();
        test_zero_settings();
        test_delay_change();
        test_disable_midway();
        test_debounce_max();
        test_max_delay();
        test_random();

        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb_button_short_long_press_detector_top OK");
        end else begin
            $display("tb_button_short_long_press_detector_top NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/bsld_pkg.sv
rtl/core/bsld_in_if.sv
rtl/core/bsld_out_if.sv
rtl/core/button_short_long_press_detector_top.sv
tb/tb_button_short_long_press_detector_top.sv
